FILE: design/slcfr_pkg.sv
`default_nettype none

package slcfr_pkg;

  localparam int unsigned SyncWidth  = 8;
  localparam int unsigned LenWidth   = 16;
  localparam int unsigned CfgWidth   = 16;
  localparam int unsigned CfgIdxWidth = 1;

  // input operation codes
  localparam logic OpByte    = 1'b0;
  localparam logic OpTimeout = 1'b1;

  // configuration register indexes
  localparam logic [CfgIdxWidth-1:0] CfgSyncValue = 1'd0;
  localparam logic [CfgIdxWidth-1:0] CfgMaxLength = 1'd1;

  // frame status codes
  localparam logic [1:0] StOk        = 2'd0;
  localparam logic [1:0] StMismatch  = 2'd1;
  localparam logic [1:0] StBadLength = 2'd2;
  localparam logic [1:0] StTimeout   = 2'd3;

  // smallest legal length field: two length bytes plus two checksum bytes
  localparam logic [LenWidth-1:0] MinLength = 16'd4;

  typedef struct packed {
    logic [SyncWidth-1:0] sync_value;
    logic [LenWidth-1:0]  max_length;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic       is_status;
    logic [7:0] body_byte;
    logic [1:0] frame_status;
  } result_t;

endpackage

`default_nettype wire

FILE: design/sync_length_checksum_frame_receiver_top.sv
`default_nettype none
// Latency: a result item is valid in the cycle after its input item is accepted.
// Throughput: one input item per cycle while in_stall_o is low; the frame state updates in a single pass.
// A pending result in the output register does not block input while it drains.
// Reset (rst_ni, async, active low): hunting first sync, frame state cleared,
// sync_value = 0x55, max_frame_length = 30, output register empty.

module sync_length_checksum_frame_receiver_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        operation_i,
  input  wire logic [7:0]  rx_byte_i,
  // result channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             is_status_o,
  output logic [7:0]       body_byte_o,
  output logic [1:0]       frame_status_o,
  // configuration write port
  input  wire logic                              cfg_we_i,
  input  wire logic [slcfr_pkg::CfgIdxWidth-1:0] cfg_index_i,
  input  wire logic [slcfr_pkg::CfgWidth-1:0]    cfg_data_i
);
  import slcfr_pkg::*;

  cfg_t    cfg_q;
  result_t result;
  logic    in_accept;

  logic       out_valid_q, out_valid_d;
  logic       is_status_q;
  logic [7:0] body_byte_q;
  logic [1:0] frame_status_q;

  // Stall only when a result is held and the sink is not taking it this cycle.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Configuration registers; the user must write them only while the block is idle, the block does not enforce it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_value <= 8'h55;
      cfg_q.max_length <= 16'd30;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgSyncValue: cfg_q.sync_value <= cfg_data_i[SyncWidth-1:0];
        CfgMaxLength: cfg_q.max_length <= cfg_data_i[LenWidth-1:0];
        default: ;
      endcase
    end
  end

  // Frame parser: holds phase, length, body count, running sum, low checksum byte.
  slcfr_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_accept),
    .operation_i (operation_i),
    .rx_byte_i   (rx_byte_i),
    .cfg_i       (cfg_q),
    .result_o    (result)
  );

  // Output register: loads on accept, empties when the sink takes the item.
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_accept) begin
      out_valid_d = result.valid;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_accept && result.valid) begin
      is_status_q    <= result.is_status;
      body_byte_q    <= result.body_byte;
      frame_status_q <= result.frame_status;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign is_status_o    = is_status_q;
  assign body_byte_o    = body_byte_q;
  assign frame_status_o = frame_status_q;

endmodule

`default_nettype wire

FILE: design/slcfr_parser.sv
`default_nettype none

module slcfr_parser (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire logic              operation_i,
  input  wire logic [7:0]        rx_byte_i,
  input  wire slcfr_pkg::cfg_t   cfg_i,
  output slcfr_pkg::result_t     result_o
);
  import slcfr_pkg::*;

  typedef enum logic [2:0] {
    PhSync1  = 3'd0,
    PhSync2  = 3'd1,
    PhLenLo  = 3'd2,
    PhLenHi  = 3'd3,
    PhBody   = 3'd4,
    PhCsLo   = 3'd5,
    PhCsHi   = 3'd6,
    PhUnused = 3'd7
  } phase_e;

  phase_e        phase_q, phase_d;
  logic [15:0]   length_q, length_d;
  logic [15:0]   remain_q, remain_d;
  logic [15:0]   sum_q, sum_d;
  logic [7:0]    cs_lo_q, cs_lo_d;

  logic [15:0]   len_full;
  logic [15:0]   sum_add;
  logic [15:0]   remain_dec;
  logic [15:0]   body_len;

  assign len_full   = {rx_byte_i, length_q[7:0]};
  assign sum_add    = sum_q + {8'd0, rx_byte_i};
  assign remain_dec = remain_q - 16'd1;
  assign body_len   = len_full - MinLength;

  always_comb begin
    phase_d  = phase_q;
    length_d = length_q;
    remain_d = remain_q;
    sum_d    = sum_q;
    cs_lo_d  = cs_lo_q;
    result_o = '0;

    if (operation_i == OpTimeout) begin
      // timeout aborts any frame in progress; ignored while hunting the first sync
      if (phase_q != PhSync1 && phase_q != PhUnused) begin
        result_o.valid        = 1'b1;
        result_o.is_status    = 1'b1;
        result_o.frame_status = StTimeout;
      end
      phase_d  = PhSync1;
      length_d = '0;
      remain_d = '0;
      sum_d    = '0;
      cs_lo_d  = '0;
    end else begin
      unique case (phase_q)
        PhSync2: begin
          phase_d = (rx_byte_i == cfg_i.sync_value) ? PhLenLo : PhSync1;
        end
        PhLenLo: begin
          length_d = {8'd0, rx_byte_i};
          sum_d    = {8'd0, rx_byte_i};
          phase_d  = PhLenHi;
        end
        PhLenHi: begin
          if (len_full < MinLength || len_full > cfg_i.max_length) begin
            result_o.valid        = 1'b1;
            result_o.is_status    = 1'b1;
            result_o.frame_status = StBadLength;
            phase_d  = PhSync1;
            length_d = '0;
            remain_d = '0;
            sum_d    = '0;
            cs_lo_d  = '0;
          end else begin
            length_d = len_full;
            sum_d    = sum_add;
            remain_d = body_len;
            phase_d  = (body_len == '0) ? PhCsLo : PhBody;
          end
        end
        PhBody: begin
          sum_d    = sum_add;
          remain_d = remain_dec;
          if (remain_dec == '0) begin
            phase_d = PhCsLo;
          end
          result_o.valid     = 1'b1;
          result_o.body_byte = rx_byte_i;
        end
        PhCsLo: begin
          cs_lo_d = rx_byte_i;
          phase_d = PhCsHi;
        end
        PhCsHi: begin
          result_o.valid        = 1'b1;
          result_o.is_status    = 1'b1;
          result_o.frame_status = ({rx_byte_i, cs_lo_q} == sum_q) ? StOk : StMismatch;
          phase_d  = PhSync1;
          length_d = '0;
          remain_d = '0;
          sum_d    = '0;
          cs_lo_d  = '0;
        end
        default: begin
          // hunting first sync; unused phase code behaves the same
          phase_d  = (rx_byte_i == cfg_i.sync_value) ? PhSync2 : PhSync1;
          length_d = '0;
          remain_d = '0;
          sum_d    = '0;
          cs_lo_d  = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhSync1;
      length_q <= '0;
      remain_q <= '0;
      sum_q    <= '0;
      cs_lo_q  <= '0;
    end else if (accept_i) begin
      phase_q  <= phase_d;
      length_q <= length_d;
      remain_q <= remain_d;
      sum_q    <= sum_d;
      cs_lo_q  <= cs_lo_d;
    end
  end

endmodule

`default_nettype wire

FILE: test/sync_length_checksum_frame_receiver_top_test.sv
`timescale 1ns / 100ps

module sync_length_checksum_frame_receiver_top_test;
  import slcfr_pkg::*;

  localparam int WatchdogLimit = 1000;
  localparam int PhaseItems    = 200;
  localparam int MaxReports    = 10;

  // --------------------------------------------------------------------------
  // Clock, reset, DUT
  // --------------------------------------------------------------------------
  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_stall_o;
  logic                   operation_i;
  logic [7:0]             rx_byte_i;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic                   is_status_o;
  logic [7:0]             body_byte_o;
  logic [1:0]             frame_status_o;
  logic                   cfg_we_i;
  logic [CfgIdxWidth-1:0] cfg_index_i;
  logic [CfgWidth-1:0]    cfg_data_i;

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  sync_length_checksum_frame_receiver_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .is_status_o    (is_status_o),
    .body_byte_o    (body_byte_o),
    .frame_status_o (frame_status_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // --------------------------------------------------------------------------
  // Frame predictor: own copy of the receiver state and its two registers
  // --------------------------------------------------------------------------
  typedef enum logic [2:0] {
    HuntFirst, HuntSecond, LenLow, LenHigh, InBody, SumLow, SumHigh
  } rx_phase_e;

  typedef struct packed {
    logic       is_status;
    logic [7:0] body_byte;
    logic [1:0] frame_status;
  } rx_result_t;

  rx_phase_e   rx_phase;
  logic [15:0] frame_len;
  logic [15:0] body_left;
  logic [15:0] sum_acc;
  logic [7:0]  cs_low;
  logic [7:0]  sync_cfg;
  logic [15:0] max_len_cfg;

  rx_result_t  expected_q[$];   // results still owed by the DUT, oldest first
  int          mismatches;
  int          items_sent;
  bit          calm;            // no idling on either side while set

  function automatic void clear_frame();
    rx_phase  = HuntFirst;
    frame_len = '0;
    body_left = '0;
    sum_acc   = '0;
    cs_low    = '0;
  endfunction

  // Advances the frame state by one item; returns 1 when a result comes out.
  function automatic bit frame_step(input logic op, input logic [7:0] b,
                                    output rx_result_t res);
    res = '0;
    if (op == OpTimeout) begin
      // ignored while hunting the first sync, otherwise aborts the frame
      if (rx_phase == HuntFirst) return 1'b0;
      res.is_status    = 1'b1;
      res.frame_status = StTimeout;
      clear_frame();
      return 1'b1;
    end
    case (rx_phase)
      HuntFirst: begin
        if (b == sync_cfg) rx_phase = HuntSecond;
      end
      HuntSecond: begin
        // a non-sync byte here is not reused as a first sync
        rx_phase = (b == sync_cfg) ? LenLow : HuntFirst;
      end
      LenLow: begin
        frame_len = {8'h00, b};
        sum_acc   = {8'h00, b};
        rx_phase  = LenHigh;
      end
      LenHigh: begin
        frame_len[15:8] = b;
        sum_acc         = sum_acc + b;
        if (frame_len < MinLength || frame_len > max_len_cfg) begin
          res.is_status    = 1'b1;
          res.frame_status = StBadLength;
          clear_frame();
          return 1'b1;
        end
        body_left = frame_len - MinLength;
        rx_phase  = (body_left == 16'd0) ? SumLow : InBody;
      end
      InBody: begin
        sum_acc   = sum_acc + b;
        body_left = body_left - 16'd1;
        if (body_left == 16'd0) rx_phase = SumLow;
        res.body_byte = b;
        return 1'b1;
      end
      SumLow: begin
        cs_low   = b;
        rx_phase = SumHigh;
      end
      default: begin
        res.is_status    = 1'b1;
        res.frame_status = ({b, cs_low} == sum_acc) ? StOk : StMismatch;
        clear_frame();
        return 1'b1;
      end
    endcase
    return 1'b0;
  endfunction

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  // Returns at the edge where the item is taken. Payload holds while stalled.
  task automatic drive_item(input logic op, input logic [7:0] b);
    while (!calm && $urandom_range(99) < 35) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    rx_byte_i   <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
    calm = (items_sent >= 400 && items_sent < 550);
  endtask

  task automatic send_item(input logic op, input logic [7:0] b);
    rx_result_t res;
    drive_item(op, b);
    if (frame_step(op, b, res)) expected_q.push_back(res);
  endtask

  // Drains the DUT; an item with no result may still be in flight, hence the
  // wait goes on after the queue empties.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxWidth-1:0] idx, input logic [15:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    if (idx == CfgSyncValue) sync_cfg = val[7:0];
    else max_len_cfg = val;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mostly short legal lengths; some exactly at the limit, some just over,
  // some far over, some under the minimum.
  function automatic logic [15:0] pick_length();
    logic [15:0] top;
    logic [15:0] len;
    top = (max_len_cfg > 16'd24) ? 16'd24 : max_len_cfg;
    case ($urandom_range(9))
      0: len = 16'($urandom_range(3));
      1: len = (max_len_cfg != 16'hFFFF) ? max_len_cfg + 16'd1 : 16'($urandom_range(3));
      2: len = (max_len_cfg != 16'hFFFF) ? 16'hFFFF : 16'($urandom_range(3));
      3: len = (max_len_cfg <= 16'd64) ? max_len_cfg : 16'd64;
      default: len = 16'($urandom_range(top, 4));
    endcase
    return len;
  endfunction

  // One frame built from the current register values. A wrong checksum is
  // made by flipping one bit; cut_at >= 0 replaces that byte with a timeout.
  task automatic send_frame(input logic [15:0] len, input bit corrupt, input int cut_at);
    logic [7:0]  frame_bytes[$];
    logic [15:0] sum;
    logic [7:0]  bb;
    frame_bytes = {sync_cfg, sync_cfg, len[7:0], len[15:8]};
    sum = len[7:0] + len[15:8];
    if (len >= MinLength && len <= max_len_cfg) begin
      repeat (len - MinLength) begin
        bb = 8'($urandom);
        frame_bytes.push_back(bb);
        sum = sum + bb;
      end
      if (corrupt) sum = sum ^ (16'd1 << $urandom_range(15));
      frame_bytes.push_back(sum[7:0]);
      frame_bytes.push_back(sum[15:8]);
    end
    for (int i = 0; i < frame_bytes.size(); i++) begin
      if (i == cut_at) begin
        send_item(OpTimeout, 8'($urandom));
        return;
      end
      send_item(OpByte, frame_bytes[i]);
    end
  endtask

  // --------------------------------------------------------------------------
  // Directed table: typed expectations where they are obvious
  // --------------------------------------------------------------------------
  typedef enum logic [1:0] {RowPredict, RowQuiet, RowBody, RowStatus} row_kind_e;

  typedef struct packed {
    logic       op;
    logic [7:0] data;
    row_kind_e  kind;
    logic [7:0] want_byte;
    logic [1:0] want_status;
  } stim_row_t;

  // register values after reset: sync 0x55, max length 30
  localparam stim_row_t DirectedRows [22] = '{
    '{OpTimeout, 8'h00, RowQuiet,   8'h00, StOk},        // timeout while hunting
    '{OpByte,    8'h55, RowQuiet,   8'h00, StOk},
    '{OpByte,    8'h00, RowQuiet,   8'h00, StOk},        // second sync missing
    '{OpByte,    8'h55, RowPredict, 8'h00, StOk},
    '{OpByte,    8'h55, RowPredict, 8'h00, StOk},
    '{OpByte,    8'h03, RowPredict, 8'h00, StOk},
    '{OpByte,    8'h00, RowStatus,  8'h00, StBadLength}, // length 3
    '{OpByte,    8'h55, RowPredict, 8'h00, StOk},
    '{OpByte,    8'h55, RowPredict, 8'h00, StOk},
    '{OpByte,    8'h04, RowPredict, 8'h00, StOk},        // empty body
    '{OpByte,    8'h00, RowQuiet,   8'h00, StOk},
    '{OpByte,    8'h04, RowQuiet,   8'h00, StOk},
    '{OpByte,    8'h00, RowStatus,  8'h00, StOk},
    '{OpByte,    8'h55, RowPredict, 8'h00, StOk},
    '{OpByte,    8'h55, RowPredict, 8'h00, StOk},
    '{OpByte,    8'h05, RowPredict, 8'h00, StOk},
    '{OpByte,    8'h00, RowPredict, 8'h00, StOk},
    '{OpByte,    8'hFF, RowBody,    8'hFF, StOk},
    '{OpByte,    8'h00, RowPredict, 8'h00, StOk},
    '{OpByte,    8'h00, RowStatus,  8'h00, StMismatch},  // sum is 0x0104
    '{OpByte,    8'h55, RowPredict, 8'h00, StOk},
    '{OpTimeout, 8'hFF, RowStatus,  8'h00, StTimeout}    // timeout after first sync
  };

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    rx_result_t res;
    rx_result_t typed;
    bit         has_res;
    int         phase_start;
    int         roll;
    int         cut;
    logic [7:0] sync_pick;
    logic [15:0] max_pick;

    rst_ni      = 1'b0;
    in_valid_i  <= 1'b0;
    operation_i <= OpByte;
    rx_byte_i   <= 8'h00;
    cfg_we_i    <= 1'b0;
    cfg_index_i <= CfgSyncValue;
    cfg_data_i  <= '0;
    sync_cfg    = 8'h55;
    max_len_cfg = 16'd30;
    mismatches  = 0;
    items_sent  = 0;
    calm        = 1'b0;
    clear_frame();

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < $size(DirectedRows); r++) begin
      drive_item(DirectedRows[r].op, DirectedRows[r].data);
      has_res = frame_step(DirectedRows[r].op, DirectedRows[r].data, res);
      typed   = '0;
      case (DirectedRows[r].kind)
        RowPredict: if (has_res) expected_q.push_back(res);
        RowBody: begin
          typed.body_byte = DirectedRows[r].want_byte;
          expected_q.push_back(typed);
        end
        RowStatus: begin
          typed.is_status    = 1'b1;
          typed.frame_status = DirectedRows[r].want_status;
          expected_q.push_back(typed);
        end
        default: ;
      endcase
    end

    // Random part over several register settings, extremes included.
    for (int p = 0; p < 5; p++) begin
      if (p > 0) begin
        settle();
        case (p)
          1: begin sync_pick = 8'h00; max_pick = MinLength; end
          2: begin sync_pick = 8'hFF; max_pick = 16'hFFFF; end
          3: begin sync_pick = 8'hA5; max_pick = 16'd12; end
          default: begin
            sync_pick = 8'($urandom);
            max_pick  = 16'($urandom_range(40, 4));
          end
        endcase
        write_reg(CfgSyncValue, {8'h00, sync_pick});
        write_reg(CfgMaxLength, max_pick);
      end
      phase_start = items_sent;
      while (items_sent - phase_start < PhaseItems) begin
        roll = $urandom_range(99);
        if (roll < 85) begin
          cut = (roll >= 75) ? int'($urandom_range(3 + max_len_cfg % 8)) : -1;
          send_frame(pick_length(), $urandom_range(6) == 0, cut);
        end else begin
          // line noise, then a timeout to get back to hunting
          repeat ($urandom_range(4, 1))
            send_item(OpByte, ($urandom_range(2) == 0) ? sync_cfg : 8'($urandom));
          send_item(OpTimeout, 8'($urandom));
        end
      end
    end

    settle();
    repeat (4) @(posedge clk_i);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("** sync_length_checksum_frame_receiver_top: PASSED **");
    end else begin
      $display("** sync_length_checksum_frame_receiver_top: FAILED **");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side: random stall, with a calm stretch
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(99) < 35);
  end

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MaxReports) $display("mismatch: %s", msg);
  endtask

  always @(posedge clk_i) begin : result_check
    rx_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        note_mismatch($sformatf("unexpected item is_status=%0d body_byte=%h status=%0d",
                                is_status_o, body_byte_o, frame_status_o));
      end else begin
        want = expected_q.pop_front();
        if (is_status_o !== want.is_status)
          note_mismatch($sformatf("is_status expected %0d got %0d",
                                  want.is_status, is_status_o));
        if (body_byte_o !== want.body_byte)
          note_mismatch($sformatf("body_byte expected %h got %h",
                                  want.body_byte, body_byte_o));
        if (frame_status_o !== want.frame_status)
          note_mismatch($sformatf("frame_status expected %0d got %0d",
                                  want.frame_status, frame_status_o));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: too long without any item moving on either side
  // --------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("timeout: nothing accepted for %0d cycles", WatchdogLimit);
      $display("** sync_length_checksum_frame_receiver_top: FAILED **");
      $finish;
    end
  end

endmodule
